// ----- hw/rtl/bbm_pkg.sv -----
// bbm_pkg: shared constants, request codes and sequencer states of the box merge table.
// No dependencies; bounding_box_merge_table in hw/rtl refers to it by scoped name.
`timescale 1ns / 1ps

package bbm_pkg;

    localparam int MAX_BOXES_DEF  = 16;
    localparam int COORD_BITS_DEF = 12;
    localparam int SLOT_W         = 4;
    localparam int SLOT_LIMIT     = 16;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_INS_END,
        ST_FL_EMPTY,
        ST_FL_LOAD
    } bbm_state_t;

endpackage

// ----- hw/rtl/bbm_store.sv -----
// bbm_store: single write port, single registered read port box memory.
// Depends on nothing; widths and depth come from the top level.
`timescale 1ns / 1ps

module bbm_store #(
    parameter int DEPTH   = 16,
    parameter int ADDR_W  = 4,
    parameter int ENTRY_W = 50
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem_reg [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/bbm_merge_unit.sv -----
// bbm_merge_unit: overlap test and bounding union of the new box with one stored box.
// Combinational; shared by every step of the table walk. No package dependencies.
`timescale 1ns / 1ps

module bbm_merge_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] nb_left,
    input  logic [COORD_BITS-1:0] nb_top,
    input  logic [COORD_BITS-1:0] nb_width,
    input  logic [COORD_BITS-1:0] nb_height,
    input  logic [COORD_BITS-1:0] sb_left,
    input  logic [COORD_BITS-1:0] sb_top,
    input  logic [COORD_BITS:0]   sb_width,
    input  logic [COORD_BITS:0]   sb_height,
    output logic                  hit,
    output logic [COORD_BITS-1:0] un_left,
    output logic [COORD_BITS-1:0] un_top,
    output logic [COORD_BITS:0]   un_width,
    output logic [COORD_BITS:0]   un_height
);

    localparam int EW = COORD_BITS + 2;

    logic [EW-1:0]         n_right, s_right, n_bot, s_bot;
    logic [EW-1:0]         min_right, min_bot, max_right, max_bot;
    logic [COORD_BITS-1:0] max_left, max_top;

    always_comb
    begin
        n_right   = EW'(nb_left) + EW'(nb_width);
        s_right   = EW'(sb_left) + EW'(sb_width);
        n_bot     = EW'(nb_top) + EW'(nb_height);
        s_bot     = EW'(sb_top) + EW'(sb_height);
        max_left  = (nb_left > sb_left) ? nb_left : sb_left;
        max_top   = (nb_top > sb_top) ? nb_top : sb_top;
        un_left   = (nb_left < sb_left) ? nb_left : sb_left;
        un_top    = (nb_top < sb_top) ? nb_top : sb_top;
        min_right = (n_right < s_right) ? n_right : s_right;
        min_bot   = (n_bot < s_bot) ? n_bot : s_bot;
        max_right = (n_right > s_right) ? n_right : s_right;
        max_bot   = (n_bot > s_bot) ? n_bot : s_bot;
        hit       = (min_right > EW'(max_left)) && (min_bot > EW'(max_top));
        un_width  = (COORD_BITS + 1)'(max_right - EW'(un_left));
        un_height = (COORD_BITS + 1)'(max_bot - EW'(un_top));
    end

endmodule

// ----- hw/rtl/bounding_box_merge_table.sv -----
// bounding_box_merge_table: per-frame box table with overlap merging.
// Depends on bbm_pkg, bbm_store and bbm_merge_unit.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: mode 0 inserts a box,
//   mode 1 flushes the table. Output channel (out_valid/out_ready) carries stored
//   boxes in slot order; the final one of a flush has last set.
// Insert: the sequencer walks the stored boxes one per cycle through the single
//   merge unit, reading the box memory ahead and writing merged boxes back.
//   in_ready stays low through the walk and the closing ST_INS_END step; the
//   one memory read port feeding the merge unit sets the pace of the walk.
// Flush: after the registered memory read, one box per cycle while out_ready is
//   high. An empty table gives a single result with table_empty set.
//   in_ready returns once the last box has entered the output register.
// Stall: the output register holds a result until taken; the flush walk pauses
//   meanwhile. A new request may be accepted while the last result still waits.
// Reset: clears box count, overflow flag, sequencer and output valid at once;
//   the box memory is not cleared and needs no sweep.
`timescale 1ns / 1ps

module bounding_box_merge_table #(
    parameter int MAX_BOXES  = bbm_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bbm_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [COORD_BITS-1:0]       box_left,
    input  logic [COORD_BITS-1:0]       box_top,
    input  logic [COORD_BITS-1:0]       box_width,
    input  logic [COORD_BITS-1:0]       box_height,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [COORD_BITS-1:0]       out_left,
    output logic [COORD_BITS-1:0]       out_top,
    output logic [COORD_BITS:0]         out_width,
    output logic [COORD_BITS:0]         out_height,
    output logic [bbm_pkg::SLOT_W-1:0]  out_slot,
    output logic                        table_empty,
    output logic                        dropped_any,
    output logic                        last
);

    localparam int CAP     = (MAX_BOXES < bbm_pkg::SLOT_LIMIT) ? MAX_BOXES
                                                               : bbm_pkg::SLOT_LIMIT;
    localparam int IDX_W   = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int CNT_W   = $clog2(CAP + 1);
    localparam int SZ_W    = COORD_BITS + 1;
    localparam int ENTRY_W = 2 * COORD_BITS + 2 * SZ_W;
    localparam int TOP_LSB = 2 * SZ_W;
    localparam int LEFT_LSB = TOP_LSB + COORD_BITS;

    bbm_pkg::bbm_state_t state_reg, state_next;

    logic [IDX_W-1:0]      idx_reg, idx_next, idx_inc;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  ovf_reg, ovf_next;
    logic                  hit_reg, hit_next;

    logic [COORD_BITS-1:0] nb_left_reg, nb_top_reg, nb_width_reg, nb_height_reg;
    logic                  load_box;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_left_reg, out_left_next, out_top_reg, out_top_next;
    logic [SZ_W-1:0]       out_width_reg, out_width_next, out_height_reg, out_height_next;
    logic [bbm_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic                  out_empty_reg, out_empty_next;
    logic                  out_drop_reg, out_drop_next;
    logic                  out_last_reg, out_last_next;

    logic                  rd_en, wr_en;
    logic [IDX_W-1:0]      rd_addr, wr_addr;
    logic [ENTRY_W-1:0]    wr_data, rd_data;

    logic [COORD_BITS-1:0] sb_left, sb_top, un_left, un_top;
    logic [SZ_W-1:0]       sb_width, sb_height, un_width, un_height;
    logic                  hit;
    logic                  walk_last, out_free;

    assign sb_left   = rd_data[LEFT_LSB +: COORD_BITS];
    assign sb_top    = rd_data[TOP_LSB +: COORD_BITS];
    assign sb_width  = rd_data[SZ_W +: SZ_W];
    assign sb_height = rd_data[0 +: SZ_W];

    bbm_store #(
        .DEPTH   (CAP),
        .ADDR_W  (IDX_W),
        .ENTRY_W (ENTRY_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bbm_merge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .nb_left   (nb_left_reg),
        .nb_top    (nb_top_reg),
        .nb_width  (nb_width_reg),
        .nb_height (nb_height_reg),
        .sb_left   (sb_left),
        .sb_top    (sb_top),
        .sb_width  (sb_width),
        .sb_height (sb_height),
        .hit       (hit),
        .un_left   (un_left),
        .un_top    (un_top),
        .un_width  (un_width),
        .un_height (un_height)
    );

    assign idx_inc   = idx_reg + IDX_W'(1);
    assign walk_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        hit_next        = hit_reg;
        load_box        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_inc;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = {un_left, un_top, un_width, un_height};
        out_valid_next  = out_valid_reg && !out_ready;
        out_left_next   = out_left_reg;
        out_top_next    = out_top_reg;
        out_width_next  = out_width_reg;
        out_height_next = out_height_reg;
        out_slot_next   = out_slot_reg;
        out_empty_next  = out_empty_reg;
        out_drop_next   = out_drop_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            bbm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    rd_addr  = '0;
                    if (mode == bbm_pkg::MODE_INSERT)
                    begin
                        load_box = 1'b1;
                        hit_next = 1'b0;
                        if (count_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            state_next = bbm_pkg::ST_INS_WALK;
                        end
                        else
                        begin
                            state_next = bbm_pkg::ST_INS_END;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = bbm_pkg::ST_FL_EMPTY;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = bbm_pkg::ST_FL_LOAD;
                    end
                end
            end

            bbm_pkg::ST_INS_WALK:
            begin
                if (hit)
                begin
                    wr_en    = 1'b1;
                    hit_next = 1'b1;
                end
                if (walk_last)
                begin
                    state_next = bbm_pkg::ST_INS_END;
                end
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_inc;
                end
            end

            bbm_pkg::ST_INS_END:
            begin
                if (!hit_reg)
                begin
                    if (count_reg < CNT_W'(CAP))
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = IDX_W'(count_reg);
                        wr_data    = {nb_left_reg, nb_top_reg,
                                      SZ_W'(nb_width_reg), SZ_W'(nb_height_reg)};
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = bbm_pkg::ST_IDLE;
            end

            bbm_pkg::ST_FL_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_left_next   = '0;
                    out_top_next    = '0;
                    out_width_next  = '0;
                    out_height_next = '0;
                    out_slot_next   = '0;
                    out_empty_next  = 1'b1;
                    out_drop_next   = ovf_reg;
                    out_last_next   = 1'b1;
                    ovf_next        = 1'b0;
                    state_next      = bbm_pkg::ST_IDLE;
                end
            end

            bbm_pkg::ST_FL_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_left_next   = sb_left;
                    out_top_next    = sb_top;
                    out_width_next  = sb_width;
                    out_height_next = sb_height;
                    out_slot_next   = bbm_pkg::SLOT_W'(idx_reg);
                    out_empty_next  = 1'b0;
                    out_drop_next   = ovf_reg;
                    out_last_next   = walk_last;
                    if (walk_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = bbm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_inc;
                    end
                end
            end

            default:
            begin
                state_next = bbm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bbm_pkg::ST_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_box)
        begin
            nb_left_reg   <= box_left;
            nb_top_reg    <= box_top;
            nb_width_reg  <= box_width;
            nb_height_reg <= box_height;
        end
        out_left_reg   <= out_left_next;
        out_top_reg    <= out_top_next;
        out_width_reg  <= out_width_next;
        out_height_reg <= out_height_next;
        out_slot_reg   <= out_slot_next;
        out_empty_reg  <= out_empty_next;
        out_drop_reg   <= out_drop_next;
        out_last_reg   <= out_last_next;
    end

    assign in_ready    = (state_reg == bbm_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_left    = out_left_reg;
    assign out_top     = out_top_reg;
    assign out_width   = out_width_reg;
    assign out_height  = out_height_reg;
    assign out_slot    = out_slot_reg;
    assign table_empty = out_empty_reg;
    assign dropped_any = out_drop_reg;
    assign last        = out_last_reg;

endmodule

// ----- bench/bounding_box_merge_table_tb.sv -----
// bounding_box_merge_table_tb: self-checking bench for the box merge table, insert and flush
// requests with random idling, a long output stall and an ungapped closing stretch.
// Depends on bbm_pkg and the bounding_box_merge_table RTL.
`timescale 1ns / 1ps

module bounding_box_merge_table_tb;

    localparam int CB        = bbm_pkg::COORD_BITS_DEF;
    localparam int SW        = bbm_pkg::SLOT_W;
    localparam int TABLE_CAP = (bbm_pkg::MAX_BOXES_DEF < bbm_pkg::SLOT_LIMIT) ?
                               bbm_pkg::MAX_BOXES_DEF : bbm_pkg::SLOT_LIMIT;
    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [CB-1:0] left;
        logic [CB-1:0] top;
        logic [CB-1:0] width;
        logic [CB-1:0] height;
    } req_box_t;

    typedef struct packed {
        logic [CB-1:0] left;
        logic [CB-1:0] top;
        logic [CB:0]   width;
        logic [CB:0]   height;
    } held_box_t;

    typedef struct packed {
        held_box_t     box;
        logic [SW-1:0] slot;
        logic          empty;
        logic          dropped;
        logic          last;
    } flush_row_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic          mode = bbm_pkg::MODE_INSERT;
    logic [CB-1:0] box_left = '0;
    logic [CB-1:0] box_top = '0;
    logic [CB-1:0] box_width = '0;
    logic [CB-1:0] box_height = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [CB-1:0] out_left;
    logic [CB-1:0] out_top;
    logic [CB:0]   out_width;
    logic [CB:0]   out_height;
    logic [SW-1:0] out_slot;
    logic          table_empty;
    logic          dropped_any;
    logic          last;

    held_box_t  held_boxes [TABLE_CAP];
    int         held_count = 0;
    logic       held_overflow = 1'b0;
    flush_row_t rows_due [$];

    int error_count = 0;
    int hold_len = 0;
    int idle_run = 0;
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;

    bounding_box_merge_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_width   (box_width),
        .box_height  (box_height),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_left    (out_left),
        .out_top     (out_top),
        .out_width   (out_width),
        .out_height  (out_height),
        .out_slot    (out_slot),
        .table_empty (table_empty),
        .dropped_any (dropped_any),
        .last        (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // merge against the box as it arrived; append only when nothing overlaps
    task automatic track_request(input logic m, input req_box_t rq);
        held_box_t     nb;
        held_box_t     sb;
        flush_row_t    row;
        logic [CB+1:0] nr, nd, sr, sd, x0, y0, x1, y1;
        logic          hit;
        int            i;
        if (m == bbm_pkg::MODE_INSERT)
        begin
            nb.left   = rq.left;
            nb.top    = rq.top;
            nb.width  = {1'b0, rq.width};
            nb.height = {1'b0, rq.height};
            nr  = (CB + 2)'(nb.left) + (CB + 2)'(nb.width);
            nd  = (CB + 2)'(nb.top) + (CB + 2)'(nb.height);
            hit = 1'b0;
            for (i = 0; i < held_count; i++)
            begin
                sb = held_boxes[i];
                sr = (CB + 2)'(sb.left) + (CB + 2)'(sb.width);
                sd = (CB + 2)'(sb.top) + (CB + 2)'(sb.height);
                x0 = (CB + 2)'((nb.left > sb.left) ? nb.left : sb.left);
                y0 = (CB + 2)'((nb.top > sb.top) ? nb.top : sb.top);
                x1 = (nr < sr) ? nr : sr;
                y1 = (nd < sd) ? nd : sd;
                if (x1 > x0 && y1 > y0)
                begin
                    hit = 1'b1;
                    held_boxes[i].left   = (nb.left < sb.left) ? nb.left : sb.left;
                    held_boxes[i].top    = (nb.top < sb.top) ? nb.top : sb.top;
                    held_boxes[i].width  = (CB + 1)'(((nr > sr) ? nr : sr)
                                           - (CB + 2)'(held_boxes[i].left));
                    held_boxes[i].height = (CB + 1)'(((nd > sd) ? nd : sd)
                                           - (CB + 2)'(held_boxes[i].top));
                end
            end
            if (!hit)
            begin
                if (held_count < TABLE_CAP)
                begin
                    held_boxes[held_count] = nb;
                    held_count++;
                end
                else
                    held_overflow = 1'b1;
            end
        end
        else
        begin
            if (held_count == 0)
            begin
                row = '0;
                row.empty   = 1'b1;
                row.dropped = held_overflow;
                row.last    = 1'b1;
                rows_due.insert(rows_due.size(), row);
            end
            for (i = 0; i < held_count; i++)
            begin
                row.box     = held_boxes[i];
                row.slot    = i[SW-1:0];
                row.empty   = 1'b0;
                row.dropped = held_overflow;
                row.last    = (i == held_count - 1);
                rows_due.insert(rows_due.size(), row);
            end
            held_count    = 0;
            held_overflow = 1'b0;
        end
    endtask

    // valid stays high across back-to-back requests; lowered only for a gap
    task automatic send_request(input logic m, input req_box_t rq);
        int gap;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        box_left   <= rq.left;
        box_top    <= rq.top;
        box_width  <= rq.width;
        box_height <= rq.height;
        do
            @(posedge clk);
        while (!in_ready);
        track_request(m, rq);
    endtask

    task automatic send_box(input int l, input int t, input int w, input int h);
        req_box_t rq;
        rq.left   = CB'(l);
        rq.top    = CB'(t);
        rq.width  = CB'(w);
        rq.height = CB'(h);
        send_request(bbm_pkg::MODE_INSERT, rq);
    endtask

    task automatic send_flush();
        req_box_t rq;
        rq = (4 * CB)'({$urandom, $urandom});
        send_request(bbm_pkg::MODE_FLUSH, rq);
    endtask

    task automatic wait_for_rows();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (rows_due.size() != 0);
    endtask

    function automatic req_box_t random_box(input bit spread, input int idx,
                                            input int bx, input int by);
        req_box_t rq;
        int       pick;
        rq   = (4 * CB)'({$urandom, $urandom});
        pick = $urandom_range(0, 15);
        if (spread)
        begin
            rq.left   = CB'((idx % 20) * 200 + $urandom_range(0, 50));
            rq.width  = CB'($urandom_range(0, 100));
        end
        else if (pick < 10)
        begin
            rq.left   = CB'(bx + $urandom_range(0, 300));
            rq.top    = CB'(by + $urandom_range(0, 300));
            rq.width  = CB'($urandom_range(1, 150));
            rq.height = CB'($urandom_range(1, 150));
        end
        else if (pick == 12)
        begin
            if ($urandom_range(0, 1))
                rq.width = '0;
            else
                rq.height = '0;
        end
        else if (pick == 13)
        begin
            rq.left   = CB'(4095 - $urandom_range(0, 3));
            rq.top    = CB'(4095 - $urandom_range(0, 3));
            rq.width  = CB'(4095 - $urandom_range(0, 3));
            rq.height = CB'(4095 - $urandom_range(0, 3));
        end
        else if (pick == 14)
        begin
            rq.left   = CB'($urandom_range(0, 3));
            rq.top    = CB'($urandom_range(0, 3));
            rq.width  = CB'(4095 - $urandom_range(0, 3));
            rq.height = CB'(4095 - $urandom_range(0, 3));
        end
        else if (pick == 15)
        begin
            rq.width  = CB'($urandom_range(1, 8));
            rq.height = CB'($urandom_range(1, 8));
        end
        return rq;
    endfunction

    // one frame: n inserts then a flush; spread frames rarely merge and so can overflow
    task automatic send_frame(input int n, input bit spread);
        int bx, by, k;
        bx = $urandom_range(0, 3700);
        by = $urandom_range(0, 3700);
        for (k = 0; k < n; k++)
            send_request(bbm_pkg::MODE_INSERT, random_box(spread, k, bx, by));
        send_flush();
    endtask

    task automatic test_empty_flush();
        req_box_t rq;
        rq = '1;
        send_request(bbm_pkg::MODE_FLUSH, rq);
        wait_for_rows();
    endtask

    // edges that only touch, zero-area boxes, a box spanning two entries, extreme corner
    task automatic test_merge_rules();
        send_box(4095, 4095, 4095, 4095);
        send_box(0, 0, 0, 0);
        send_box(100, 100, 50, 50);
        send_box(150, 100, 50, 50);
        send_box(100, 150, 50, 0);
        send_box(140, 140, 20, 20);
        send_box(4000, 4000, 200, 200);
    endtask

    // carries on from the merge test's five entries
    task automatic test_table_full();
        int k;
        for (k = 0; k < TABLE_CAP - 5; k++)
            send_box(k * 300 + 7, 1000, 0, 4095);
        send_box(4095, 0, 0, 0);
        send_box(4050, 4050, 100, 100);
        send_flush();
        send_flush();
        wait_for_rows();
    endtask

    task automatic test_random_frames(input int quota);
        int  sent, n;
        bit  spread;
        sent = 0;
        while (sent < quota)
        begin
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            spread    = ($urandom_range(0, 6) == 0);
            n = spread ? $urandom_range(14, 22) : $urandom_range(0, 10);
            send_frame(n, spread);
            sent += n + 1;
        end
        wait_for_rows();
    endtask

    task automatic test_output_stall();
        send_gaps = 1'b0;
        hold_len  = 400;
        send_frame(8, 1'b0);
        send_frame(16, 1'b1);
        send_frame(4, 1'b0);
        send_gaps = 1'b1;
        wait_for_rows();
    endtask

    task automatic test_back_to_back(input int quota);
        int sent, n;
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        sent = 0;
        while (sent < quota)
        begin
            n = $urandom_range(0, 12);
            send_frame(n, $urandom_range(0, 4) == 0);
            sent += n + 1;
        end
        wait_for_rows();
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        flush_row_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (rows_due.size() == 0)
            begin
                $display("%0t: box out expected none, got slot %0d", $time, out_slot);
                error_count++;
            end
            else
            begin
                want = rows_due.pop_front();
                check_field("out_left", 16'(want.box.left), 16'(out_left));
                check_field("out_top", 16'(want.box.top), 16'(out_top));
                check_field("out_width", 16'(want.box.width), 16'(out_width));
                check_field("out_height", 16'(want.box.height), 16'(out_height));
                check_field("out_slot", 16'(want.slot), 16'(out_slot));
                check_field("table_empty", 16'(want.empty), 16'(table_empty));
                check_field("dropped_any", 16'(want.dropped), 16'(dropped_any));
                check_field("last", 16'(want.last), 16'(last));
            end
        end
    end

    initial
    begin
        int gap;
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            else if (recv_gaps && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 19);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run == STALL_LIMIT)
        begin
            $display("bounding_box_merge_table_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_flush();
        test_merge_rules();
        test_table_full();
        test_random_frames(260);
        test_output_stall();
        test_back_to_back(40);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("bounding_box_merge_table_tb: done, clean");
        else
            $display("bounding_box_merge_table_tb: done, errors");
        $finish;
    end

endmodule
